[hw/rtl/rros_pkg.sv]
// package: shared types, codes and constants of the round-robin scheduler
package rros_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [7:0] QUANTUM_RST  = 8'd2;
    localparam logic [7:0] OVERHEAD_RST = 8'd1;
    localparam logic [4:0] COUNT_RST    = 5'd1;

    // request modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_QUANTUM  = 2'd0;
    localparam logic [1:0] CFG_OVERHEAD = 2'd1;
    localparam logic [1:0] CFG_COUNT    = 2'd2;
    localparam logic [1:0] CFG_NONE     = 2'd3;

    // reported task states
    localparam logic [2:0] TS_NOT_ARRIVED = 3'd0;
    localparam logic [2:0] TS_WAITING     = 3'd1;
    localparam logic [2:0] TS_EXECUTING   = 3'd2;
    localparam logic [2:0] TS_OVERHEAD    = 3'd3;
    localparam logic [2:0] TS_COMPLETED   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic [15:0] arrival_tick;
        logic [7:0]  burst_length;
    } in_t;

    typedef struct packed {
        logic [3:0]  task_index;
        logic [2:0]  task_state;
        logic [15:0] tick_number;
        logic        last_of_tick;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_SCAN,
        ST_CHK,
        ST_CHK2,
        ST_DISP,
        ST_DISP2,
        ST_RD,
        ST_EMIT
    } state_t;

endpackage

[hw/rtl/rros_ram.sv]
// generic single write port ram with registered read
module rros_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/round_robin_overhead_scheduler_unit.sv]
// top level: tick-driven round-robin scheduler with quantum and switch overhead
//
// A load request writes the arrival and burst tables as it is accepted. A restart
// request sweeps the burst table into the remaining-work table, one slot a cycle.
// A tick request scans the arrival table for the slots in use, checks the running
// task, dispatches the ring head when the ring is nonempty, no task runs and no
// overhead is pending, then reads and reports the state of each slot in turn,
// holding while the output stalls. The tables have one read port and registered
// reads, so every slot goes through them one at a time. Results leave through an
// output register, so the next request is taken while the final result still waits.
module round_robin_overhead_scheduler_unit
    import rros_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_TASKS);

    state_t state_reg, state_next;

    logic [7:0]           quantum_reg, quantum_next;
    logic [7:0]           overhead_reg, overhead_next;
    logic [4:0]           count_reg, count_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic                 run_vld_reg, run_vld_next;
    logic [IDX_W-1:0]     run_idx_reg, run_idx_next;
    logic [7:0]           qused_reg, qused_next;
    logic [7:0]           ovh_reg, ovh_next;
    logic [15:0]          tick_reg, tick_next;
    logic [MAX_TASKS-1:0] ovflag_reg, ovflag_next;
    logic                 out_valid_reg, out_valid_next;
    out_t                 out_reg, out_next;

    // memory ports
    logic             arr_we, burst_we, work_we, ring_we;
    logic [IDX_W-1:0] load_addr, k_idx, work_waddr, work_raddr, ring_waddr;
    logic [15:0]      arr_rdata;
    logic [7:0]       burst_rdata, work_rdata, work_wdata;
    logic [IDX_W-1:0] ring_wdata, ring_rdata;

    logic             accept, load_ok, out_free;
    logic [CNT_W-1:0] n_eff;
    logic             push_req;
    logic [IDX_W-1:0] push_slot;
    logic [CNT_W-1:0] pos_sum;
    logic             can_push;
    logic             is_run, last;
    logic [2:0]       ts;
    logic [7:0]       ovh_dec;
    logic             dispatch;

    assign k_idx     = k_reg[IDX_W-1:0];
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load_addr = IDX_W'(in_data.slot);
    assign load_ok   = accept && (in_data.mode == MODE_LOAD) && (int'(in_data.slot) < MAX_TASKS);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // effective task count
    always_comb
    begin
        if (count_reg == 5'd0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(count_reg) > MAX_TASKS)
        begin
            n_eff = MAX_C;
        end
        else
        begin
            n_eff = CNT_W'(count_reg);
        end
    end

    // ring tail position
    always_comb
    begin
        pos_sum = CNT_W'(head_reg) + fill_reg;
        if (pos_sum >= MAX_C)
        begin
            pos_sum = pos_sum - MAX_C;
        end
    end
    assign ring_waddr = pos_sum[IDX_W-1:0];
    assign can_push   = fill_reg < MAX_C;
    assign ring_we    = push_req && can_push;
    assign ring_wdata = push_slot;

    // table memories
    assign arr_we   = load_ok;
    assign burst_we = load_ok;

    rros_ram #(.WIDTH(16), .DEPTH(MAX_TASKS)) u_arr (
        .clk(clk), .we(arr_we), .waddr(load_addr), .wdata(in_data.arrival_tick),
        .raddr(k_idx), .rdata(arr_rdata)
    );

    rros_ram #(.WIDTH(8), .DEPTH(MAX_TASKS)) u_burst (
        .clk(clk), .we(burst_we), .waddr(load_addr), .wdata(in_data.burst_length),
        .raddr(k_idx), .rdata(burst_rdata)
    );

    assign work_raddr = (state_reg == ST_CHK) ? run_idx_reg : k_idx;

    rros_ram #(.WIDTH(8), .DEPTH(MAX_TASKS)) u_work (
        .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
        .raddr(work_raddr), .rdata(work_rdata)
    );

    rros_ram #(.WIDTH(IDX_W), .DEPTH(MAX_TASKS)) u_ring (
        .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
        .raddr(head_reg), .rdata(ring_rdata)
    );

    // slot state decode for reporting
    always_comb
    begin
        is_run = run_vld_reg && (run_idx_reg == k_idx);
        last   = (k_reg == n_eff - CNT_W'(1));
        ovh_dec = (ovh_reg != 8'd0) ? ovh_reg - 8'd1 : ovh_reg;
        if (ovflag_reg[k_idx])
        begin
            ts = TS_OVERHEAD;
        end
        else if (is_run)
        begin
            ts = TS_EXECUTING;
        end
        else if (arr_rdata <= tick_reg && work_rdata != 8'd0)
        begin
            ts = TS_WAITING;
        end
        else if (arr_rdata > tick_reg)
        begin
            ts = TS_NOT_ARRIVED;
        end
        else
        begin
            ts = TS_COMPLETED;
        end
    end

    assign dispatch = !run_vld_reg && (fill_reg != '0) && (ovh_reg == 8'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.mode == MODE_TICK)
                begin
                    state_next = ST_SCAN;
                end
                else if (accept && in_data.mode == MODE_RESTART)
                begin
                    state_next = ST_CLR;
                end
            end
            ST_CLR:
            begin
                if (k_reg == MAX_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (k_reg == n_eff)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:   state_next = ST_CHK2;
            ST_CHK2:  state_next = ST_DISP;
            ST_DISP:  state_next = dispatch ? ST_DISP2 : ST_RD;
            ST_DISP2: state_next = ST_RD;
            ST_RD:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last ? ST_IDLE : ST_RD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        quantum_next   = quantum_reg;
        overhead_next  = overhead_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        run_vld_next   = run_vld_reg;
        run_idx_next   = run_idx_reg;
        qused_next     = qused_reg;
        ovh_next       = ovh_reg;
        tick_next      = tick_reg;
        ovflag_next    = ovflag_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        push_req       = 1'b0;
        push_slot      = run_idx_reg;
        work_we        = 1'b0;
        work_waddr     = k_idx;
        work_wdata     = burst_rdata;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUANTUM:  quantum_next  = cfg_data;
                CFG_OVERHEAD: overhead_next = cfg_data;
                CFG_COUNT:    count_next    = cfg_data[4:0];
                default:      ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (accept && in_data.mode == MODE_RESTART)
                begin
                    head_next    = '0;
                    fill_next    = '0;
                    run_vld_next = 1'b0;
                    qused_next   = 8'd0;
                    ovh_next     = 8'd0;
                    tick_next    = 16'd0;
                    ovflag_next  = '0;
                end
            end
            ST_CLR:
            begin
                // copy burst into remaining work, one slot behind the read
                if (k_reg != '0)
                begin
                    work_we    = 1'b1;
                    work_waddr = IDX_W'(k_reg - CNT_W'(1));
                    work_wdata = burst_rdata;
                end
                k_next = k_reg + CNT_W'(1);
            end
            ST_SCAN:
            begin
                // enqueue arrivals, one slot behind the read
                if (k_reg != '0 && arr_rdata == tick_reg)
                begin
                    push_req  = 1'b1;
                    push_slot = IDX_W'(k_reg - CNT_W'(1));
                    if (can_push)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                k_next = (k_reg == n_eff) ? '0 : k_reg + CNT_W'(1);
            end
            ST_CHK: ;
            ST_CHK2:
            begin
                // preempt or release the running task
                if (run_vld_reg && (qused_reg >= quantum_reg || work_rdata == 8'd0))
                begin
                    if (qused_reg >= quantum_reg && work_rdata != 8'd0)
                    begin
                        ovflag_next[run_idx_reg] = 1'b1;
                        push_req  = 1'b1;
                        push_slot = run_idx_reg;
                        if (can_push)
                        begin
                            fill_next = fill_reg + CNT_W'(1);
                        end
                        ovh_next = (overhead_reg == 8'd0) ? 8'd1 : overhead_reg;
                    end
                    run_vld_next = 1'b0;
                    qused_next   = 8'd0;
                end
            end
            ST_DISP: ;
            ST_DISP2:
            begin
                // take the ring head
                run_vld_next = 1'b1;
                run_idx_next = ring_rdata;
                head_next    = (int'(head_reg) == MAX_TASKS - 1) ? '0 : head_reg + IDX_W'(1);
                fill_next    = fill_reg - CNT_W'(1);
            end
            ST_RD: ;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.task_index   = 4'(k_idx);
                    out_next.task_state   = ts;
                    out_next.tick_number  = tick_reg;
                    out_next.last_of_tick = last;
                    if (ovflag_reg[k_idx])
                    begin
                        ovh_next = ovh_dec;
                        if (ovh_dec == 8'd0)
                        begin
                            ovflag_next[k_idx] = 1'b0;
                        end
                    end
                    else if (is_run)
                    begin
                        work_we    = 1'b1;
                        work_waddr = k_idx;
                        work_wdata = (work_rdata != 8'd0) ? work_rdata - 8'd1 : work_rdata;
                        if (qused_reg != 8'hFF)
                        begin
                            qused_next = qused_reg + 8'd1;
                        end
                    end
                    if (last)
                    begin
                        k_next = '0;
                        if (tick_reg != 16'hFFFF)
                        begin
                            tick_next = tick_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quantum_reg   <= QUANTUM_RST;
            overhead_reg  <= OVERHEAD_RST;
            count_reg     <= COUNT_RST;
            k_reg         <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            run_vld_reg   <= 1'b0;
            run_idx_reg   <= '0;
            qused_reg     <= 8'd0;
            ovh_reg       <= 8'd0;
            tick_reg      <= 16'd0;
            ovflag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quantum_reg   <= quantum_next;
            overhead_reg  <= overhead_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            run_vld_reg   <= run_vld_next;
            run_idx_reg   <= run_idx_next;
            qused_reg     <= qused_next;
            ovh_reg       <= ovh_next;
            tick_reg      <= tick_next;
            ovflag_reg    <= ovflag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // ring never overfills
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= MAX_C)
        else $error("ready ring overfilled");

    // a new result only comes from the report step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside report step");

    // dispatch only happens with a nonempty ring and no pending overhead
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DISP2 |-> $past(fill_reg != '0 && ovh_reg == 8'd0))
        else $error("dispatch without queued task");

endmodule
